// ----- rtl/tid_pkg.sv -----
`default_nettype none

package tid_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned COUNT_W = 4;

   localparam logic [BYTE_W-1:0] SIGN_NIBBLE_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEN_NIBBLE_MASK  = 8'h0F;

   localparam logic [3:0] TAG_LEN1 = 4'h1;
   localparam logic [3:0] TAG_LEN2 = 4'h2;
   localparam logic [3:0] TAG_LEN3 = 4'h3;
   localparam logic [3:0] TAG_LEN4 = 4'h4;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic               bad_tag;
   } tid_result_type;

   // Magnitude byte count for a length code; zero marks an unknown code.
   function automatic logic [COUNT_W-1:0] length_for_code(input logic [3:0] code);
      logic [COUNT_W-1:0] n;
      unique case (code)
         TAG_LEN1: n = 4'd1;
         TAG_LEN2: n = 4'd2;
         TAG_LEN3: n = 4'd4;
         TAG_LEN4: n = 4'd8;
         default:  n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tid_accum.sv -----
`default_nettype none

module tid_accum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [tid_pkg::BYTE_W-1:0]    stream_byte,
   output tid_pkg::tid_result_type            result
);
   import tid_pkg::*;

   logic [COUNT_W-1:0] bytes_left_ff, bytes_left_in;
   logic               is_negative_ff, is_negative_in;
   logic [VALUE_W-1:0] magnitude_acc_ff, magnitude_acc_in;
   logic [COUNT_W-1:0] tag_len;
   logic [3:0]         len_code;

   assign len_code = stream_byte[3:0] & LEN_NIBBLE_MASK[3:0];
   assign tag_len  = length_for_code(len_code);

   always_comb begin
      bytes_left_in    = bytes_left_ff;
      is_negative_in   = is_negative_ff;
      magnitude_acc_in = magnitude_acc_ff;
      result.valid     = 1'b0;
      result.bad_tag   = 1'b0;
      result.value     = '0;
      if (step) begin
         if (bytes_left_ff == '0) begin
            if (tag_len == '0) begin
               // unknown tag: flag it, drop the byte, stay on tag
               result.valid   = 1'b1;
               result.bad_tag = 1'b1;
            end else begin
               is_negative_in   = (stream_byte & SIGN_NIBBLE_MASK) != '0;
               magnitude_acc_in = '0;
               bytes_left_in    = tag_len;
            end
         end else begin
            magnitude_acc_in = {magnitude_acc_ff[VALUE_W-BYTE_W-1:0], stream_byte};
            bytes_left_in    = bytes_left_ff - 4'd1;
            if (bytes_left_ff == 4'd1) begin
               result.valid = 1'b1;
               result.value = is_negative_ff ? (VALUE_W'(0) - magnitude_acc_in)
                                             : magnitude_acc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff    <= '0;
         is_negative_ff   <= 1'b0;
         magnitude_acc_ff <= '0;
      end else begin
         bytes_left_ff    <= bytes_left_in;
         is_negative_ff   <= is_negative_in;
         magnitude_acc_ff <= magnitude_acc_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tid_out_reg.sv -----
`default_nettype none

module tid_out_reg (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  tid_pkg::tid_result_type            result,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [tid_pkg::VALUE_W-1:0]        rsp_tdata,
   output logic [0:0]                         rsp_tuser
);
   import tid_pkg::*;

   logic               valid_ff, valid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               bad_ff, bad_in;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      bad_in   = bad_ff;
      if (load) begin
         valid_in = result.valid;
         if (result.valid) begin
            value_in = result.value;
            bad_in   = result.bad_tag;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      bad_ff   <= bad_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = bad_ff;

endmodule

`default_nettype wire

// ----- rtl/tagged_integer_decoder_top.sv -----
`default_nettype none

// Tagged integer decoder. Takes one stream byte per word on req_ and returns
// one 64-bit two's complement value per complete integer on rsp_. An integer
// is a tag byte (high nibble zero = positive, else negative; low nibble 1..4
// = 1, 2, 4 or 8 big-endian magnitude bytes) followed by its magnitude bytes;
// the result is the magnitude, negated modulo 2^64 for a negative tag. A tag
// with any other low nibble yields one word with tuser set and value zero,
// and the next byte is again read as a tag. There is no timeout on a partial
// integer. An accepted byte sits in the input register; once the output
// register is free or emptying, the byte is decoded and any result it
// completes loads the output register, which drives rsp_tvalid.
// One byte is taken every cycle while rsp_tready is high. While a result
// waits to be taken the input register can still take one byte; after that
// req_tready stays low until the waiting word is taken.
module tagged_integer_decoder_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] stream_byte
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [tid_pkg::VALUE_W-1:0]        rsp_tdata,   // [63:0] decoded_value
   output logic [0:0]                         rsp_tuser    // [0] bad_tag
);
   import tid_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              advance;
   tid_result_type    result;

   // the decode stage moves when the output register is free or emptying
   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   tid_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .stream_byte (in_byte_ff),
      .result      (result)
   );

   tid_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a bad tag word always carries a zero value
   a_bad_tag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("bad tag word with non-zero value");

   // a decoded result reaches the output register on the next edge
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (advance && result.valid) |=> rsp_tvalid)
      else $error("decoded result lost");

   // a byte held in the input register is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_tready)
      else $error("input register overrun");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the tagged integer decoder.
// A byte stream of tagged integers goes in on req_, one byte per word; decoded
// 64-bit values (or an unknown-tag flag) come back on rsp_. Every accepted byte
// is run through a local decoder model and any word it yields is queued; each
// returned word is checked, field by field, against the oldest queued one.
module tb;
   import tid_pkg::*;

   localparam int unsigned RAND_WORDS = 1750;  // random bytes after the table
   localparam int unsigned QUIET_TAIL = 150;   // last random bytes sent with no idling
   localparam int unsigned HOLD_AT    = 400;   // random byte count that triggers the long hold
   localparam int unsigned HOLD_LEN   = 200;   // receiver hold-off, in cycles
   localparam int unsigned DRAIN      = 12;    // margin for stray words after the drain
   localparam int unsigned LIMIT      = 400000;

   // One row of the directed table. With fixed set, the row's value and bad_tag
   // are the word this byte must produce; otherwise the local model decides.
   typedef struct packed {
      logic [BYTE_W-1:0]  stream_byte;
      logic               fixed;
      logic [VALUE_W-1:0] value;
      logic               bad_tag;
   } table_row_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               bad_tag;
   } int_word_type;

   localparam int unsigned TABLE_N = 23;
   localparam table_row_type STIM_TABLE [TABLE_N] = '{
      // unknown tags: length nibble zero, then a high-nibble-set tag with code five
      '{8'h00, 1'b1, 64'd0, 1'b1},
      '{8'hF5, 1'b1, 64'd0, 1'b1},
      // positive, one byte, largest byte
      '{8'h01, 1'b0, 64'd0, 1'b0},
      '{8'hFF, 1'b1, 64'd255, 1'b0},
      // negative zero
      '{8'hF1, 1'b0, 64'd0, 1'b0},
      '{8'h00, 1'b1, 64'd0, 1'b0},
      // negative, two bytes
      '{8'h22, 1'b0, 64'd0, 1'b0},
      '{8'h12, 1'b0, 64'd0, 1'b0},
      '{8'h34, 1'b0, 64'd0, 1'b0},
      // positive, four bytes
      '{8'h03, 1'b0, 64'd0, 1'b0},
      '{8'hDE, 1'b0, 64'd0, 1'b0},
      '{8'hAD, 1'b0, 64'd0, 1'b0},
      '{8'hBE, 1'b0, 64'd0, 1'b0},
      '{8'hEF, 1'b0, 64'd0, 1'b0},
      // most negative magnitude: negated 2^63 wraps to itself
      '{8'hF4, 1'b0, 64'd0, 1'b0},
      '{8'h80, 1'b0, 64'd0, 1'b0},
      '{8'h00, 1'b0, 64'd0, 1'b0},
      '{8'h00, 1'b0, 64'd0, 1'b0},
      '{8'h00, 1'b0, 64'd0, 1'b0},
      '{8'h00, 1'b0, 64'd0, 1'b0},
      '{8'h00, 1'b0, 64'd0, 1'b0},
      '{8'h00, 1'b0, 64'd0, 1'b0},
      '{8'h00, 1'b1, 64'h8000_0000_0000_0000, 1'b0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata = 8'h00;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [VALUE_W-1:0] rsp_tdata;
   logic [0:0]         rsp_tuser;

   // local decoder state
   logic [COUNT_W-1:0] bytes_owed = '0;
   logic               neg_tag = 1'b0;
   logic [VALUE_W-1:0] mag_acc = '0;

   int_word_type       pending_words [$];

   int unsigned        fail_count = 0;
   int unsigned        words_sent = 0;
   int unsigned        values_seen = 0;
   int unsigned        bad_tags_seen = 0;
   int unsigned        cycle_count = 0;
   bit                 quiet_tail = 1'b0;
   bit                 long_hold_pending = 1'b0;

   tagged_integer_decoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] stream_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [63:0] decoded_value
      .rsp_tuser  (rsp_tuser)     // [0] bad_tag
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run guard: a correct run finishes far inside this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Local decoder: takes one stream byte, returns 1 when it completes a word.
   // A tag sets up sign and byte count; magnitude bytes shift in big-endian.
   function automatic bit decode_stream_byte(input logic [BYTE_W-1:0] b,
                                             output logic [VALUE_W-1:0] value,
                                             output logic bad);
      logic [3:0] code;
      code  = b[3:0];
      value = '0;
      bad   = 1'b0;
      if (bytes_owed == 0) begin
         if (code >= TAG_LEN1 && code <= TAG_LEN4) begin
            neg_tag    = (b & SIGN_NIBBLE_MASK) != 0;
            mag_acc    = '0;
            bytes_owed = 4'd1 << (code - TAG_LEN1);   // 1, 2, 4 or 8
            return 1'b0;
         end
         // unknown length code: byte dropped, flagged word with zero value
         bad = 1'b1;
         return 1'b1;
      end
      mag_acc    = {mag_acc[VALUE_W-9:0], b};
      bytes_owed = bytes_owed - 1'b1;
      if (bytes_owed != 0)
         return 1'b0;
      value = neg_tag ? -mag_acc : mag_acc;   // wraps modulo 2^64
      return 1'b1;
   endfunction

   // Offers one byte on req_. Called at a falling edge, returns at a falling
   // edge. Valid stays high across back-to-back words; it is lowered only for a
   // gap, so each edge sees one assignment at most.
   task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic fixed,
                             input logic [VALUE_W-1:0] fixed_value,
                             input logic fixed_bad);
      int_word_type w;
      logic [VALUE_W-1:0] v;
      logic bad;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      // queue before the word can be taken; no result appears earlier anyway
      if (decode_stream_byte(b, v, bad) || fixed) begin
         w.value   = fixed ? fixed_value : v;
         w.bad_tag = fixed ? fixed_bad : bad;
         pending_words.push_back(w);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      @(negedge clock);
   endtask

   // Receiver: runs of ready with random stall bursts, one long hold-off on
   // request, and no stalls at all once the quiet tail starts.
   initial begin
      @(negedge clock);
      forever begin
         if (long_hold_pending) begin
            // sender keeps offering: the block fills and must stall req_
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
   end

   // Result checker: every word taken on rsp_ against the oldest expectation.
   always @(posedge clock) begin
      int_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result word: decoded_value %h bad_tag %0d",
                   rsp_tdata, rsp_tuser[0]);
            fail_count++;
         end else begin
            w = pending_words.pop_front();
            if (rsp_tdata !== w.value) begin
               $error("decoded_value: expected %h, got %h", w.value, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[0] !== w.bad_tag) begin
               $error("bad_tag: expected %0d, got %0d", w.bad_tag, rsp_tuser[0]);
               fail_count++;
            end
            if (w.bad_tag)
               bad_tags_seen++;
            else
               values_seen++;
         end
      end
   end

   // Stimulus
   initial begin
      int unsigned rand_sent;
      int unsigned pick;
      int unsigned n_bytes;
      int unsigned fill;
      logic [3:0]  hi_nib;
      logic [3:0]  lo_nib;
      logic [7:0]  mb;
      bit          hold_done;

      hold_done = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int i = 0; i < TABLE_N; i++)
         offer_byte(STIM_TABLE[i].stream_byte, STIM_TABLE[i].fixed,
                    STIM_TABLE[i].value, STIM_TABLE[i].bad_tag);

      // random part: mostly well-formed integers, some unknown tags and noise
      rand_sent = 0;
      while (rand_sent < RAND_WORDS) begin
         quiet_tail = rand_sent >= RAND_WORDS - QUIET_TAIL;
         if (!hold_done && rand_sent >= HOLD_AT) begin
            long_hold_pending = 1'b1;
            hold_done = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            // noise: any byte where a tag is due
            offer_byte(8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
            rand_sent++;
         end else if (pick <= 2) begin
            // unknown length code: zero or five to fifteen
            lo_nib = 4'($urandom_range(0, 11));
            if (lo_nib != 0)
               lo_nib = lo_nib + 4'd4;
            offer_byte({4'($urandom_range(0, 15)), lo_nib}, 1'b0, '0, 1'b0);
            rand_sent++;
         end else begin
            hi_nib = ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
            lo_nib = 4'($urandom_range(TAG_LEN1, TAG_LEN4));
            n_bytes = 1 << (lo_nib - TAG_LEN1);
            fill = $urandom_range(0, 7);   // 0: zeros, 1: ones, 2: top bit only
            offer_byte({hi_nib, lo_nib}, 1'b0, '0, 1'b0);
            rand_sent++;
            for (int k = 0; k < n_bytes; k++) begin
               case (fill)
                  0:       mb = 8'h00;
                  1:       mb = 8'hFF;
                  2:       mb = (k == 0) ? 8'h80 : 8'h00;
                  default: mb = 8'($urandom_range(0, 255));
               endcase
               offer_byte(mb, 1'b0, '0, 1'b0);
               rand_sent++;
            end
         end
      end
      req_tvalid <= 1'b0;

      // drain: all expected words back, then a few cycles for strays
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("Sent %0d stream bytes; %0d values and %0d unknown-tag words came back.",
               words_sent, values_seen, bad_tags_seen);
      $display("Covered all length codes, both signs, unknown tags and a long output stall.");
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
